@@ sv/caff_container_validator_defines.svh @@
// assertion macros for the caff container validator
`ifndef CAFF_CONTAINER_VALIDATOR_DEFINES_SVH
`define CAFF_CONTAINER_VALIDATOR_DEFINES_SVH
// implication check clocked on clk with async reset
`define CAFF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define CAFF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ sv/caff_pkg.sv @@
// shared types and constants of the caff container validator
package caff_pkg;
	localparam logic [4:0] PH_HDR_ID     = 5'd0;
	localparam logic [4:0] PH_HDR_LEN    = 5'd1;
	localparam logic [4:0] PH_CAFF_MAGIC = 5'd2;
	localparam logic [4:0] PH_HDR_SIZE   = 5'd3;
	localparam logic [4:0] PH_NUM_ANIM   = 5'd4;
	localparam logic [4:0] PH_CRED_ID    = 5'd5;
	localparam logic [4:0] PH_CRED_LEN   = 5'd6;
	localparam logic [4:0] PH_DATE       = 5'd7;
	localparam logic [4:0] PH_CREATOR_N  = 5'd8;
	localparam logic [4:0] PH_CREATOR    = 5'd9;
	localparam logic [4:0] PH_ANIM_ID    = 5'd10;
	localparam logic [4:0] PH_ANIM_LEN   = 5'd11;
	localparam logic [4:0] PH_DURATION   = 5'd12;
	localparam logic [4:0] PH_CIFF_MAGIC = 5'd13;
	localparam logic [4:0] PH_CIFF_HSIZE = 5'd14;
	localparam logic [4:0] PH_CONTENT    = 5'd15;
	localparam logic [4:0] PH_WIDTH      = 5'd16;
	localparam logic [4:0] PH_HEIGHT     = 5'd17;
	localparam logic [4:0] PH_CAPTION    = 5'd18;
	localparam logic [4:0] PH_TAGS       = 5'd19;
	localparam logic [4:0] PH_PIXELS     = 5'd20;
	localparam logic [4:0] PH_DONE       = 5'd21;
	localparam logic [4:0] PH_ERROR      = 5'd22;
	localparam logic [4:0] PH_MUL        = 5'd23;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_HDR_ID  = 3'd1;
	localparam logic [2:0] ST_CAFF    = 3'd2;
	localparam logic [2:0] ST_CRED_ID = 3'd3;
	localparam logic [2:0] ST_ANIM_ID = 3'd4;
	localparam logic [2:0] ST_CIFF    = 3'd5;
	localparam logic [2:0] ST_CONTENT = 3'd6;
	localparam logic [2:0] ST_LENGTH  = 3'd7;

	localparam logic [7:0] ID_HEADER  = 8'd1;
	localparam logic [7:0] ID_CREDITS = 8'd2;
	localparam logic [7:0] ID_ANIM    = 8'd3;
	localparam logic [7:0] NEWLINE    = 8'h0a;
	localparam int unsigned DATE_BYTES = 6;

	// commands from controller to datapath
	typedef struct packed {
		logic       clear_all;   // return to reset values (the size product register is kept)
		logic       take_word;   // shift data byte into accumulator
		logic       cnt_inc;     // bump byte counter
		logic       cnt_clr;
		logic       load_anims;
		logic       load_dur;
		logic       load_hsize;
		logic       load_content;
		logic       load_width;
		logic       load_height;
		logic       load_skip_word;
		logic       load_skip_tags;
		logic       load_skip_pix;
		logic       dec_skip;
		logic       finish_anim;
		logic       hdr_seen_inc;
		logic       hdr_seen_clr;
		logic       mul_start;
		logic       mul_step;
	} caff_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [3:0] cnt;
		logic       word_last;   // this byte completes a word
		logic       word_zero;   // completed word is zero
		logic       skip_one;    // skip counter equals one
		logic       anims_zero;
		logic       anims_one;
		logic       tags_left;   // header size exceeds bytes seen
		logic       content_zero;
		logic       mul_done;
		logic       size_ok;
	} caff_sts_t;

	function automatic logic [7:0] caff_magic(input logic [1:0] i);
		case (i)
			2'd0: caff_magic = 8'h43;
			2'd1: caff_magic = 8'h41;
			default: caff_magic = 8'h46;
		endcase
	endfunction

	function automatic logic [7:0] ciff_sig_byte(input logic [1:0] i);
		case (i)
			2'd0: ciff_sig_byte = 8'h43;
			2'd1: ciff_sig_byte = 8'h49;
			default: ciff_sig_byte = 8'h46;
		endcase
	endfunction
endpackage

@@ sv/caff_datapath.sv @@
// datapath: field accumulator, counters, held fields and size multiplier
module caff_datapath import caff_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       data_byte,
	input  caff_cmd_t        cmd,
	output caff_sts_t        sts,
	output logic [63:0]      anim_number,
	output logic [63:0]      duration,
	output logic [63:0]      width,
	output logic [63:0]      height
);
	logic [3:0]  cnt_q;
	logic [63:0] shift_q, anims_q, num_q, dur_q, hsize_q, content_q;
	logic [63:0] width_q, height_q, skip_q, seen_q;
	logic [63:0] word;
	logic [63:0] wh_q, acc_q;
	logic [1:0]  mstep_q;
	logic        mdone_q;
	logic [63:0] pp;
	logic [63:0] seen_now;

	// complete word including the byte in flight
	assign word = shift_q | ({56'd0, data_byte} << {cnt_q[2:0], 3'b000});
	// header bytes counted including this one
	assign seen_now = seen_q + 64'd1;

	// 64x64 low product by 32x32 partial products: step0 lo*lo, 1 lo*hi, 2 hi*lo
	always_comb begin
		case (mstep_q)
			2'd0: pp = 64'(width_q[31:0]) * 64'(height_q[31:0]);
			2'd1: pp = {width_q[31:0] * height_q[63:32], 32'd0};
			2'd2: pp = {width_q[63:32] * height_q[31:0], 32'd0};
			default: pp = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; shift_q <= '0; anims_q <= '0; num_q <= '0;
			dur_q <= '0; hsize_q <= '0; content_q <= '0; width_q <= '0;
			height_q <= '0; skip_q <= '0; seen_q <= '0;
			wh_q <= '0; acc_q <= '0; mstep_q <= '0; mdone_q <= 1'b0;
		end else if (cmd.clear_all) begin
			cnt_q <= '0; shift_q <= '0; anims_q <= '0; num_q <= '0;
			dur_q <= '0; hsize_q <= '0; content_q <= '0; width_q <= '0;
			height_q <= '0; skip_q <= '0; seen_q <= '0;
			mstep_q <= '0; mdone_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + 4'd1;
			if (cmd.take_word) shift_q <= (cnt_q == 4'd7) ? 64'd0 : word;
			if (cmd.hdr_seen_clr) seen_q <= '0;
			else if (cmd.hdr_seen_inc) seen_q <= seen_now;
			if (cmd.load_anims) anims_q <= word;
			if (cmd.load_dur) dur_q <= word;
			if (cmd.load_hsize) hsize_q <= word;
			if (cmd.load_content) content_q <= word;
			if (cmd.load_width) width_q <= word;
			if (cmd.load_height) height_q <= word;
			if (cmd.load_skip_word) skip_q <= word;
			else if (cmd.load_skip_tags) skip_q <= hsize_q - seen_now;
			else if (cmd.load_skip_pix) skip_q <= content_q;
			else if (cmd.dec_skip) skip_q <= skip_q - 64'd1;
			if (cmd.finish_anim) begin
				anims_q <= anims_q - 64'd1;
				num_q <= num_q + 64'd1;
			end
			if (cmd.mul_start) begin
				mstep_q <= '0; acc_q <= '0; mdone_q <= 1'b0;
			end else if (cmd.mul_step) begin
				if (mstep_q == 2'd3) begin
					// times three as x + 2x
					wh_q <= acc_q + {acc_q[62:0], 1'b0};
					mdone_q <= 1'b1;
				end else begin
					acc_q <= acc_q + pp;
					mstep_q <= mstep_q + 2'd1;
				end
			end
		end
	end

	assign sts.cnt          = cnt_q;
	assign sts.word_last    = (cnt_q == 4'd7);
	assign sts.word_zero    = (word == 64'd0);
	assign sts.skip_one     = (skip_q == 64'd1);
	assign sts.anims_zero   = (anims_q == 64'd0);
	assign sts.anims_one    = (anims_q == 64'd1);
	assign sts.tags_left    = (hsize_q > seen_now);
	assign sts.content_zero = (content_q == 64'd0);
	assign sts.mul_done     = mdone_q;
	assign sts.size_ok      = (wh_q == content_q);

	assign anim_number = num_q;
	assign duration    = dur_q;
	assign width       = width_q;
	assign height      = height_q;
endmodule

@@ sv/caff_ctrl.sv @@
// controller: phase sequencing, magic and id checks, handshakes
module caff_ctrl import caff_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_file,
	input  logic       out_ready,
	output logic       out_valid,
	output logic       out_final,
	output logic [2:0] out_status,
	output logic       out_capture,
	input  caff_sts_t  sts,
	output caff_cmd_t  cmd
);
	logic [4:0] phase_q, phase_d;
	logic [2:0] err_q, err_d;
	logic       eof_q;       // eof byte parked during the multiply
	logic       acc;
	logic       report;
	logic       fin;
	logic [2:0] fin_status;
	logic       eof_d;

	// not in the size check, and the output register is free or drains this cycle
	assign in_ready = (phase_q != PH_MUL) && (!out_valid || out_ready);
	assign acc = in_valid && in_ready;

	function automatic logic [4:0] after_anims(input logic zero);
		after_anims = zero ? PH_DONE : PH_ANIM_ID;
	endfunction

	always_comb begin
		cmd = '0;
		phase_d = phase_q;
		err_d = err_q;
		report = 1'b0;
		fin = 1'b0;
		fin_status = ST_OK;
		eof_d = eof_q;
		if (phase_q == PH_MUL) begin
			cmd.mul_step = 1'b1;
			if (sts.mul_done) begin
				if (!sts.size_ok) begin
					phase_d = PH_ERROR; err_d = ST_CONTENT;
				end else begin
					phase_d = PH_CAPTION; report = !eof_q;
				end
				if (eof_q) begin
					fin = 1'b1;
					fin_status = sts.size_ok ? ST_LENGTH : ST_CONTENT;
				end
				cmd.mul_step = 1'b0;
			end
		end else if (acc) begin
			if (phase_q >= PH_CIFF_MAGIC && phase_q <= PH_CAPTION) cmd.hdr_seen_inc = 1'b1;
			case (phase_q)
				PH_HDR_ID:
					if (data_byte != ID_HEADER) begin
						phase_d = PH_ERROR; err_d = ST_HDR_ID;
					end else phase_d = PH_HDR_LEN;
				PH_CRED_ID:
					if (data_byte != ID_CREDITS) begin
						phase_d = PH_ERROR; err_d = ST_CRED_ID;
					end else phase_d = PH_CRED_LEN;
				PH_ANIM_ID:
					if (data_byte != ID_ANIM) begin
						phase_d = PH_ERROR; err_d = ST_ANIM_ID;
					end else phase_d = PH_ANIM_LEN;
				PH_CAFF_MAGIC, PH_CIFF_MAGIC: begin
					if (data_byte != ((phase_q == PH_CAFF_MAGIC) ?
							caff_magic(sts.cnt[1:0]) : ciff_sig_byte(sts.cnt[1:0]))) begin
						phase_d = PH_ERROR;
						err_d = (phase_q == PH_CAFF_MAGIC) ? ST_CAFF : ST_CIFF;
					end else if (sts.cnt == 4'd3) begin
						cmd.cnt_clr = 1'b1;
						phase_d = (phase_q == PH_CAFF_MAGIC) ? PH_HDR_SIZE : PH_CIFF_HSIZE;
					end else cmd.cnt_inc = 1'b1;
				end
				PH_DATE:
					if (sts.cnt == 4'(DATE_BYTES - 1)) begin
						cmd.cnt_clr = 1'b1; phase_d = PH_CREATOR_N;
					end else cmd.cnt_inc = 1'b1;
				PH_HDR_LEN, PH_HDR_SIZE, PH_NUM_ANIM, PH_CRED_LEN, PH_CREATOR_N,
				PH_ANIM_LEN, PH_DURATION, PH_CIFF_HSIZE, PH_CONTENT, PH_WIDTH,
				PH_HEIGHT: begin
					cmd.take_word = 1'b1;
					if (sts.word_last) begin
						cmd.cnt_clr = 1'b1;
						case (phase_q)
							PH_HDR_LEN: phase_d = PH_CAFF_MAGIC;
							PH_HDR_SIZE: phase_d = PH_NUM_ANIM;
							PH_NUM_ANIM: begin cmd.load_anims = 1'b1; phase_d = PH_CRED_ID; end
							PH_CRED_LEN: phase_d = PH_DATE;
							PH_CREATOR_N: begin
								cmd.load_skip_word = 1'b1;
								phase_d = sts.word_zero ? after_anims(sts.anims_zero) : PH_CREATOR;
							end
							PH_ANIM_LEN: phase_d = PH_DURATION;
							PH_DURATION: begin
								cmd.load_dur = 1'b1; cmd.hdr_seen_clr = 1'b1;
								phase_d = PH_CIFF_MAGIC;
							end
							PH_CIFF_HSIZE: begin cmd.load_hsize = 1'b1; phase_d = PH_CONTENT; end
							PH_CONTENT: begin cmd.load_content = 1'b1; phase_d = PH_WIDTH; end
							PH_WIDTH: begin cmd.load_width = 1'b1; phase_d = PH_HEIGHT; end
							default: begin
								cmd.load_height = 1'b1; cmd.mul_start = 1'b1;
								phase_d = PH_MUL;
							end
						endcase
					end else cmd.cnt_inc = 1'b1;
				end
				PH_CREATOR: begin
					cmd.dec_skip = 1'b1;
					if (sts.skip_one) phase_d = after_anims(sts.anims_zero);
				end
				PH_CAPTION:
					if (data_byte == NEWLINE) begin
						if (sts.tags_left) begin
							cmd.load_skip_tags = 1'b1; phase_d = PH_TAGS;
						end else if (sts.content_zero) begin
							cmd.finish_anim = 1'b1; phase_d = after_anims(sts.anims_one);
						end else begin
							cmd.load_skip_pix = 1'b1; phase_d = PH_PIXELS;
						end
					end
				PH_TAGS: begin
					cmd.dec_skip = 1'b1;
					if (sts.skip_one) begin
						if (sts.content_zero) begin
							cmd.finish_anim = 1'b1; phase_d = after_anims(sts.anims_one);
						end else begin
							cmd.load_skip_pix = 1'b1; phase_d = PH_PIXELS;
						end
					end
				end
				PH_PIXELS: begin
					cmd.dec_skip = 1'b1;
					if (sts.skip_one) begin
						cmd.finish_anim = 1'b1; phase_d = after_anims(sts.anims_one);
					end
				end
				PH_ERROR: ;
				default: begin phase_d = PH_ERROR; err_d = ST_LENGTH; end
			endcase
			if (end_of_file) begin
				if (phase_d == PH_MUL) begin
					// status waits for the size check
					eof_d = 1'b1;
				end else begin
					fin = 1'b1;
					if (phase_d == PH_ERROR) fin_status = err_d;
					else if (phase_d == PH_DONE) fin_status = ST_OK;
					else fin_status = ST_LENGTH;
				end
			end
		end
		if (fin) begin
			cmd = '0;
			cmd.clear_all = 1'b1;
			phase_d = PH_HDR_ID;
			err_d = ST_OK;
			eof_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR_ID;
			err_q <= ST_OK;
			eof_q <= 1'b0;
			out_valid <= 1'b0;
			out_final <= 1'b0;
			out_status <= ST_OK;
		end else begin
			phase_q <= phase_d;
			err_q <= err_d;
			eof_q <= eof_d;
			if (fin || report) begin
				out_valid <= 1'b1;
				out_final <= fin;
				out_status <= fin ? fin_status : ST_OK;
			end else if (out_ready) out_valid <= 1'b0;
		end
	end

	assign out_capture = report;
endmodule

@@ sv/caff_container_validator.sv @@
// Streaming CAFF container checker. One byte is accepted per cycle on the
// input channel while no stall holds it off: the input stalls while the
// result register is full and not drained, and after the last CIFF height
// byte, while the 64-bit content-size product is formed from 32x32 partial
// products, tripled and compared. A report (report_kind 0) follows each valid
// CIFF header that does not end the file; the byte marked end_of_file yields a
// final status (report_kind 1) and returns the checker to its reset state. One
// result register sits between the sides; outside the size check a new byte is
// taken whenever it is empty or being drained.
module caff_container_validator import caff_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        report_kind,
	output logic [2:0]  status,
	output logic [63:0] anim_index,
	output logic [63:0] anim_duration,
	output logic [63:0] pic_width,
	output logic [63:0] pic_height
);
`include "caff_container_validator_defines.svh"
	caff_cmd_t   cmd;
	caff_sts_t   sts;
	logic        capture;
	logic [63:0] num, dur, wid, hgt;
	logic [63:0] idx_q, dur_q, wid_q, hgt_q;

	caff_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .data_byte(data_byte), .cmd(cmd), .sts(sts),
		.anim_number(num), .duration(dur), .width(wid), .height(hgt)
	);

	caff_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .end_of_file(end_of_file), .out_ready(out_ready),
		.out_valid(out_valid), .out_final(report_kind), .out_status(status),
		.out_capture(capture), .sts(sts), .cmd(cmd)
	);

	// report fields; a final status shows zeros
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0; dur_q <= '0; wid_q <= '0; hgt_q <= '0;
		end else if (capture) begin
			idx_q <= num; dur_q <= dur; wid_q <= wid; hgt_q <= hgt;
		end
	end

	assign anim_index    = report_kind ? 64'd0 : idx_q;
	assign anim_duration = report_kind ? 64'd0 : dur_q;
	assign pic_width     = report_kind ? 64'd0 : wid_q;
	assign pic_height    = report_kind ? 64'd0 : hgt_q;

	`CAFF_ASSERT_IMP(a_report_ok, out_valid && !report_kind, status == ST_OK)
	`CAFF_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(status))
	`CAFF_ASSERT_IMP(a_one_cmd_clear, cmd.clear_all, !cmd.take_word && !cmd.finish_anim)
endmodule

@@ dv/caff_container_validator_checker.sv @@
// result checker for the caff container validator: predicts reports from the byte stream
`timescale 1ns / 100ps
module caff_container_validator_checker import caff_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        report_kind,
	input  logic [2:0]  status,
	input  logic [63:0] anim_index,
	input  logic [63:0] anim_duration,
	input  logic [63:0] pic_width,
	input  logic [63:0] pic_height,
	output int          fail_count,
	output int          pending_count
);
	typedef struct packed {
		logic        kind;
		logic [2:0]  st;
		logic [63:0] idx;
		logic [63:0] dur;
		logic [63:0] wid;
		logic [63:0] hgt;
	} report_t;

	report_t     report_q[$];
	logic [4:0]  ph;
	logic [3:0]  cnt;
	logic [63:0] acc, anims_left, anim_num, dur, hsize, csize, wid, hgt, skip, hseen;
	logic        err;
	logic [2:0]  err_code;

	assign pending_count = report_q.size();

	task automatic clear_state();
		ph = PH_HDR_ID; cnt = '0; acc = '0; anims_left = '0; anim_num = '0; dur = '0;
		hsize = '0; csize = '0; wid = '0; hgt = '0; skip = '0; hseen = '0; err = 1'b0;
		err_code = ST_OK;
	endtask

	function automatic void set_err(input logic [2:0] code);
		err = 1'b1;
		err_code = code;
	endfunction

	function automatic bit word_in(input logic [7:0] b, output logic [63:0] v);
		acc |= 64'(b) << (8 * cnt[2:0]);
		cnt = cnt + 4'd1;
		v = acc;
		if (cnt >= 4'd8) begin
			acc = '0;
			cnt = '0;
			return 1;
		end
		return 0;
	endfunction

	// 0 mismatch, 1 more, 2 complete
	function automatic int magic_in(input logic [7:0] b, input bit ciff);
		logic [7:0] m;
		m = ciff ? ciff_sig_byte(cnt[1:0]) : caff_magic(cnt[1:0]);
		if (cnt[1:0] == 2'd3) m = 8'h46;
		if (b != m) return 0;
		cnt = cnt + 4'd1;
		if (cnt >= 4'd4) begin
			cnt = '0;
			return 2;
		end
		return 1;
	endfunction

	function automatic void enter_anims();
		ph = (anims_left == 0) ? PH_DONE : PH_ANIM_ID;
	endfunction

	function automatic void end_anim();
		anims_left--;
		anim_num++;
		enter_anims();
	endfunction

	function automatic void enter_pixels();
		skip = csize;
		if (skip == 0) end_anim();
		else ph = PH_PIXELS;
	endfunction

	function automatic bit advance(input logic [7:0] b);
		logic [63:0] v;
		int m;
		if (err) return 0;
		if (ph >= PH_CIFF_MAGIC && ph <= PH_CAPTION) hseen++;
		case (ph)
			PH_HDR_ID: if (b != ID_HEADER) set_err(ST_HDR_ID); else ph = PH_HDR_LEN;
			PH_HDR_LEN: if (word_in(b, v)) ph = PH_CAFF_MAGIC;
			PH_CAFF_MAGIC: begin
				m = magic_in(b, 0);
				if (m == 0) set_err(ST_CAFF); else if (m == 2) ph = PH_HDR_SIZE;
			end
			PH_HDR_SIZE: if (word_in(b, v)) ph = PH_NUM_ANIM;
			PH_NUM_ANIM: if (word_in(b, v)) begin
				anims_left = v;
				ph = PH_CRED_ID;
			end
			PH_CRED_ID: if (b != ID_CREDITS) set_err(ST_CRED_ID); else ph = PH_CRED_LEN;
			PH_CRED_LEN: if (word_in(b, v)) ph = PH_DATE;
			PH_DATE: begin
				cnt = cnt + 4'd1;
				if (cnt >= 4'(DATE_BYTES)) begin
					cnt = '0;
					ph = PH_CREATOR_N;
				end
			end
			PH_CREATOR_N: if (word_in(b, v)) begin
				skip = v;
				if (v == 0) enter_anims(); else ph = PH_CREATOR;
			end
			PH_CREATOR: begin
				skip--;
				if (skip == 0) enter_anims();
			end
			PH_ANIM_ID: if (b != ID_ANIM) set_err(ST_ANIM_ID); else ph = PH_ANIM_LEN;
			PH_ANIM_LEN: if (word_in(b, v)) ph = PH_DURATION;
			PH_DURATION: if (word_in(b, v)) begin
				dur = v;
				hseen = '0;
				ph = PH_CIFF_MAGIC;
			end
			PH_CIFF_MAGIC: begin
				m = magic_in(b, 1);
				if (m == 0) set_err(ST_CIFF); else if (m == 2) ph = PH_CIFF_HSIZE;
			end
			PH_CIFF_HSIZE: if (word_in(b, v)) begin
				hsize = v;
				ph = PH_CONTENT;
			end
			PH_CONTENT: if (word_in(b, v)) begin
				csize = v;
				ph = PH_WIDTH;
			end
			PH_WIDTH: if (word_in(b, v)) begin
				wid = v;
				ph = PH_HEIGHT;
			end
			PH_HEIGHT: if (word_in(b, v)) begin
				hgt = v;
				if (csize != 64'(64'd3 * wid * hgt)) begin
					set_err(ST_CONTENT);
					return 0;
				end
				ph = PH_CAPTION;
				return 1;
			end
			PH_CAPTION: if (b == NEWLINE) begin
				if (hsize > hseen) begin
					skip = hsize - hseen;
					ph = PH_TAGS;
				end else begin
					enter_pixels();
				end
			end
			PH_TAGS: begin
				skip--;
				if (skip == 0) enter_pixels();
			end
			PH_PIXELS: begin
				skip--;
				if (skip == 0) end_anim();
			end
			default: set_err(ST_LENGTH);
		endcase
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		report_t exp_r;
		bit rep;
		int errs;
		errs = 0;
		if (!arst_n) begin
			clear_state();
			fail_count <= 0;
			report_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (report_q.size() == 0) begin
					$error("result transfer with no result expected");
					errs++;
				end else begin
					exp_r = report_q.pop_front();
					if (exp_r.kind != report_kind) begin
						$error("report_kind exp %0d got %0d", exp_r.kind, report_kind);
						errs++;
					end
					if (exp_r.st != status) begin
						$error("status exp %0d got %0d", exp_r.st, status);
						errs++;
					end
					if (exp_r.idx != anim_index) begin
						$error("anim_index exp %0h got %0h", exp_r.idx, anim_index);
						errs++;
					end
					if (exp_r.dur != anim_duration) begin
						$error("anim_duration exp %0h got %0h", exp_r.dur, anim_duration);
						errs++;
					end
					if (exp_r.wid != pic_width) begin
						$error("pic_width exp %0h got %0h", exp_r.wid, pic_width);
						errs++;
					end
					if (exp_r.hgt != pic_height) begin
						$error("pic_height exp %0h got %0h", exp_r.hgt, pic_height);
						errs++;
					end
				end
			end
			if (in_valid && in_ready) begin
				rep = advance(data_byte);
				if (end_of_file) begin
					exp_r = '0;
					exp_r.kind = 1'b1;
					exp_r.st = err ? err_code : (ph == PH_DONE ? ST_OK : ST_LENGTH);
					report_q = {report_q, exp_r};
					clear_state();
				end else if (rep) begin
					exp_r = '{1'b0, ST_OK, anim_num, dur, wid, hgt};
					report_q = {report_q, exp_r};
				end
			end
			fail_count <= fail_count + errs;
		end
	end
endmodule

@@ dv/caff_container_validator_tb.sv @@
// testbench top for the caff container validator: builds file streams and gives the verdict
`timescale 1ns / 100ps
module caff_container_validator_tb import caff_pkg::*; ();

	logic        clk = 0, arst_n = 0;
	logic        in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [7:0]  data_byte = 0;
	logic        end_of_file = 0;
	logic        report_kind;
	logic [2:0]  status;
	logic [63:0] anim_index, anim_duration, pic_width, pic_height;
	int          fail_count, pending_count;
	int          sent = 0;
	logic [7:0]  file_bytes[$];

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	caff_container_validator u_dut (.*);

	caff_container_validator_checker u_chk (.*);

	// receiver stalls at random per transfer, with quiet stretches
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			repeat (w) @(posedge clk);
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			out_ready <= 0;
		end
	end

	task automatic add_byte(input logic [7:0] b);
		file_bytes = {file_bytes, b};
	endtask

	task automatic put_word(input logic [63:0] v);
		for (int i = 0; i < 8; i++) add_byte(v[8*i +: 8]);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	// build a file; flaw picks one corruption, zero for a clean file
	task automatic build_file(input int n_anim, input int flaw, input logic [63:0] wbig);
		logic [63:0] w, h, hs;
		int cap, tags, err_at;
		file_bytes.delete();
		add_byte(flaw == 1 ? 8'h07 : ID_HEADER);
		put_word(rnd64());
		add_byte("C"); add_byte("A");
		add_byte("F"); add_byte(flaw == 2 ? 8'h58 : "F");
		put_word(rnd64());
		put_word(64'(n_anim));
		add_byte(flaw == 3 ? 8'h03 : ID_CREDITS);
		put_word(rnd64());
		for (int i = 0; i < DATE_BYTES; i++) add_byte(8'($urandom()));
		cap = $urandom_range(0, 3);
		put_word(64'(cap));
		repeat (cap) add_byte(8'($urandom()));
		for (int a = 0; a < n_anim; a++) begin
			add_byte(flaw == 4 && a == n_anim - 1 ? 8'hff : ID_ANIM);
			put_word(rnd64());
			put_word(a == 0 && wbig != 0 ? 64'hffff_ffff_ffff_ffff : rnd64());
			add_byte("C");
			add_byte(flaw == 5 ? 8'h00 : "I");
			add_byte("F"); add_byte("F");
			w = 64'($urandom_range(0, 2));
			h = 64'($urandom_range(0, 2));
			if (wbig != 0 && a == 0) begin
				w = wbig;
				h = rnd64();
			end
			cap = $urandom_range(0, 3);
			tags = $urandom_range(0, 3);
			// header: magic, 4 words, caption plus newline, tags; maybe too small
			hs = 64'(36 + cap + 1 + tags);
			if ($urandom_range(0, 4) == 0) hs = 64'($urandom_range(0, 40));
			put_word(hs);
			put_word(flaw == 6 ? 64'd3 * w * h + 64'd1 : 64'd3 * w * h);
			put_word(w);
			put_word(h);
			if (wbig != 0 && a == 0) begin
				// huge pixel count would be endless; end the file here
				return;
			end
			repeat (cap) add_byte($urandom_range(0, 1) ? (8'h0a ^ 8'h01) : 8'($urandom() | 32'h80));
			add_byte(NEWLINE);
			if (hs > 36 + cap + 1) repeat (hs - 37 - cap) add_byte(8'($urandom()));
			repeat (3 * w * h) add_byte(8'($urandom()));
		end
		if (flaw == 7) add_byte(8'($urandom()));
		if (flaw == 8) begin
			err_at = $urandom_range(1, file_bytes.size() - 1);
			while (file_bytes.size() > err_at) void'(file_bytes.pop_back());
		end
		if (flaw == 9) file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom());
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eof);
		int w;
		w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
		if (w > 0) begin
			in_valid <= 0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1;
		data_byte <= b;
		end_of_file <= eof;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: single-byte files of extreme values
		send_byte(8'h00, 1);
		send_byte(8'hff, 1);
		send_byte(ID_HEADER, 1);
		for (int f = 0; f <= 7; f++) begin
			build_file(1, f, 0);
			send_file();
		end
		build_file(0, 0, 0);
		send_file();
		build_file(1, 0, 64'hffff_ffff_ffff_ffff);
		send_file();
		in_valid <= 0;
		while (pending_count != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		while (sent < 1950) begin
			build_file($urandom_range(0, 3),
				($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0,
				($urandom_range(0, 15) == 0) ? rnd64() : 64'd0);
			send_file();
		end
		in_valid <= 0;
		while (pending_count != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("PASS caff_container_validator");
		else
			$display("FAIL caff_container_validator");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL caff_container_validator");
		$finish;
	end
endmodule
